@@ rtl/signed_integer_to_custom_radix_text_macros.svh @@
// Assertion macros for the signed integer to custom radix text block.
// Included by the datapath, the one module that carries concurrent checks; no dependencies.
`ifndef SIGNED_INTEGER_TO_CUSTOM_RADIX_TEXT_MACROS_SVH
`define SIGNED_INTEGER_TO_CUSTOM_RADIX_TEXT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SICRT_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define SICRT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define SICRT_ASSERT_IMPL(lbl, clk, rstn, pre, post, msg)
`define SICRT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

@@ rtl/sicrt_pkg.sv @@
// Shared types and constants for the custom radix text block.
// No dependencies; imported by controller, datapath and top level.
`timescale 1ns / 1ps

package sicrt_pkg;

  localparam int NUM_W      = 32;
  localparam int CHAR_W     = 8;
  localparam int REG_W      = 64;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CHARS      = 64;
  localparam int CHAR_IDX_W = 6;
  localparam int STEP_BITS  = 4;
  localparam int STEPS      = NUM_W / STEP_BITS;
  localparam int STEP_CNT_W = $clog2(STEPS);
  localparam int MAX_DIGITS = 32;
  localparam int PTR_W      = $clog2(MAX_DIGITS);
  localparam int SP_W       = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic scan_init;
    logic scan_step;
    logic load;
    logic div_step;
    logic push;
    logic emit_sign;
    logic emit_digit;
  } sicrt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic base_ok;
    logic neg;
    logic num_zero;
    logic stack_empty;
    logic last_digit;
  } sicrt_sts_t;

endpackage

@@ rtl/sicrt_ctrl.sv @@
// Controller for the custom radix text block: sequences alphabet check,
// sign, digit division and character output. Depends on sicrt_pkg.
`timescale 1ns / 1ps

module sicrt_ctrl import sicrt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       cfg_we_i,
  input  sicrt_sts_t sts_i,
  output sicrt_cmd_t cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SIGN,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [STEP_CNT_W-1:0]  step_q, step_d;
  logic                   dirty_q, dirty_d;

  assign busy_o = dirty_q | (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (dirty_q) begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else if (start_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          if (sts_i.base_ok) begin
            state_d = ST_SIGN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sign = sts_i.neg;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (step_q == '0 && sts_i.num_zero && !sts_i.stack_empty) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
          if (step_q == STEP_CNT_W'(STEPS - 1)) begin
            cmd_o.push = 1'b1;
            step_d     = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.last_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a write during a check leaves the flag set, so the check reruns
    dirty_d = cfg_we_i | (dirty_q & ~cmd_o.scan_init);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      dirty_q <= 1'b1;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      dirty_q <= dirty_d;
    end
  end

endmodule

@@ rtl/sicrt_dp.sv @@
// Datapath for the custom radix text block: alphabet registers, alphabet
// check, radix-16 step divider, digit stack and output registers.
// Depends on sicrt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "signed_integer_to_custom_radix_text_macros.svh"

module sicrt_dp import sicrt_pkg::*; #(
  parameter int MAX_BASE = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [REG_W-1:0]         cfg_wdata_i,
  input  logic signed [NUM_W-1:0]  number_value_i,
  input  sicrt_cmd_t               cmd_i,
  output sicrt_sts_t               sts_o,
  output logic                     text_valid_o,
  output logic [CHAR_W-1:0]        text_char_o,
  output logic                     last_char_o
);

  localparam int LEN_W = $clog2(MAX_BASE + 1);
  localparam int DIG_W = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
  localparam int REM_W = DIG_W + 1;

  logic [REG_W-1:0]   alpha_q [NUM_REGS];
  logic [CHAR_W-1:0]  chars [CHARS];

  logic [LEN_W-1:0]   scan_idx_q;
  logic [LEN_W-1:0]   base_len_q;
  logic               base_ok_q;
  logic [CHAR_W-1:0]  scan_char;
  logic [MAX_BASE-1:0] dup_lane;
  logic               scan_end;
  logic               scan_bad;

  logic [NUM_W-1:0]   num_q, num_d;
  logic [DIG_W-1:0]   rem_q, rem_d;
  logic               neg_q;
  logic [REM_W-1:0]   base_ext;

  logic [DIG_W-1:0]   stack_q [MAX_DIGITS];
  logic [SP_W-1:0]    sp_q;
  logic [SP_W-1:0]    sp_m1;
  logic [DIG_W-1:0]   top_digit;

  logic               out_valid_q;
  logic [CHAR_W-1:0]  out_char_q;
  logic               out_last_q;

  // alphabet registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        alpha_q[i] <= '0;
      end
    end else if (cfg_we_i && cfg_idx_i < CFG_IDX_W'(NUM_REGS)) begin
      alpha_q[cfg_idx_i[$clog2(NUM_REGS)-1:0]] <= cfg_wdata_i;
    end
  end

  for (genvar k = 0; k < CHARS; k++) begin : g_chars
    assign chars[k] = alpha_q[k / 8][(k % 8) * CHAR_W +: CHAR_W];
  end

  // alphabet check: one character per cycle against all earlier ones
  assign scan_char = chars[CHAR_IDX_W'(scan_idx_q)];

  for (genvar j = 0; j < MAX_BASE; j++) begin : g_dup
    assign dup_lane[j] = (LEN_W'(j) < scan_idx_q) && (chars[j] == scan_char);
  end

  assign scan_end = (scan_idx_q == LEN_W'(MAX_BASE)) || (scan_char == '0);
  assign scan_bad = !scan_end &&
                    ((scan_char == CH_PLUS) || (scan_char == CH_MINUS) || (|dup_lane));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      base_len_q <= '0;
      base_ok_q  <= 1'b0;
    end else if (cmd_i.scan_init) begin
      scan_idx_q <= '0;
      base_ok_q  <= 1'b0;
    end else if (cmd_i.scan_step) begin
      if (scan_end || scan_bad) begin
        base_ok_q  <= scan_end && (scan_idx_q >= LEN_W'(2));
        base_len_q <= scan_idx_q;
      end else begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
  end

  // divider: STEP_BITS restoring steps per cycle, quotient shifts into num
  assign base_ext = REM_W'(base_len_q);

  always_comb begin
    logic [REM_W-1:0] r;
    logic [NUM_W-1:0] n;
    logic [DIG_W-1:0] rm;
    rm = rem_q;
    n  = num_q;
    for (int k = 0; k < STEP_BITS; k++) begin
      r = {rm, n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (r >= base_ext) begin
        r    = r - base_ext;
        n[0] = 1'b1;
      end
      rm = r[DIG_W-1:0];
    end
    num_d = n;
    rem_d = rm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      sp_q  <= '0;
    end else if (cmd_i.load) begin
      rem_q <= '0;
      sp_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= cmd_i.push ? '0 : rem_d;
      if (cmd_i.push) begin
        sp_q <= sp_q + 1'b1;
      end
    end else if (cmd_i.emit_digit) begin
      sp_q <= sp_m1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q <= number_value_i[NUM_W-1];
      num_q <= number_value_i[NUM_W-1] ? (NUM_W'(0) - NUM_W'(number_value_i))
                                       : NUM_W'(number_value_i);
    end else if (cmd_i.div_step) begin
      num_q <= num_d;
    end
  end

  // digit stack, least significant digit pushed first
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && cmd_i.push) begin
      stack_q[sp_q[PTR_W-1:0]] <= rem_d;
    end
  end

  assign sp_m1     = sp_q - 1'b1;
  assign top_digit = stack_q[sp_m1[PTR_W-1:0]];

  // output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_sign | cmd_i.emit_digit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_sign) begin
      out_char_q <= CH_MINUS;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      out_char_q <= chars[CHAR_IDX_W'(top_digit)];
      out_last_q <= (sp_q == SP_W'(1));
    end
  end

  assign text_valid_o = out_valid_q;
  assign text_char_o  = out_char_q;
  assign last_char_o  = out_last_q;

  assign sts_o.scan_done   = scan_end | scan_bad;
  assign sts_o.base_ok     = base_ok_q;
  assign sts_o.neg         = neg_q;
  assign sts_o.num_zero    = (num_q == '0);
  assign sts_o.stack_empty = (sp_q == '0);
  assign sts_o.last_digit  = (sp_q == SP_W'(1));

  `SICRT_ASSERT_IMPL(a_rem_below_base, clk_i, rst_ni, base_ok_q, REM_W'(rem_q) < base_ext, "remainder not below base")
  `SICRT_ASSERT_IMPL(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= SP_W'(MAX_DIGITS), "digit stack overflow")
  `SICRT_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, cmd_i.emit_digit, sp_q != '0, "pop from empty digit stack")
  `SICRT_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, out_valid_q && out_last_q, !out_valid_q, "transfer after last character")

endmodule

@@ rtl/signed_integer_to_custom_radix_text.sv @@
// Signed 32-bit integer to text in a configurable alphabet radix, MSB first.
// The sign character, for a negative number, comes first, then the radix-16 step
// divider builds the digits, a check finds the number used up, then one character
// per cycle goes out; one item at a time. Results cannot be stalled.
// Reset (async, active low) clears the alphabet; after reset or any config
// write busy stays high while the alphabet is checked.
`timescale 1ns / 1ps

module signed_integer_to_custom_radix_text import sicrt_pkg::*; #(
  parameter int MAX_BASE = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [NUM_W-1:0]  number_value_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [REG_W-1:0]         cfg_wdata_i,
  output logic                     text_valid_o,
  output logic [CHAR_W-1:0]        text_char_o,
  output logic                     last_char_o
);

  sicrt_cmd_t cmd;
  sicrt_sts_t sts;

  sicrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cfg_we_i (cfg_we_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  sicrt_dp #(
    .MAX_BASE (MAX_BASE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .number_value_i (number_value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .text_valid_o   (text_valid_o),
    .text_char_o    (text_char_o),
    .last_char_o    (last_char_o)
  );

endmodule

@@ verif/tb_top.sv @@
// Testbench for signed_integer_to_custom_radix_text: programs alphabets, sends numbers
// and checks every emitted character and last flag against a local text predictor.
// Depends on sicrt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sicrt_pkg::*;

  localparam int MAX_BASE     = 64;
  localparam int RANDOM_ITEMS = 186;
  localparam int LATENCY_CYC  = 9 * MAX_DIGITS + MAX_BASE + 16;
  localparam int TIMEOUT_CYC  = 500000;

  typedef enum logic [3:0] {
    ALPHA_RESET, ALPHA_DEC, ALPHA_BIN, ALPHA_HEX, ALPHA_FULL,
    ALPHA_SHORT, ALPHA_DUP, ALPHA_PLUS, ALPHA_MINUS
  } alphabet_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  typedef struct {
    alphabet_e         alpha;
    logic [NUM_W-1:0]  number;
    bit                typed;
    string             text;
  } directed_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic signed [NUM_W-1:0] number_value_i;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [REG_W-1:0]        cfg_wdata_i;
  logic                    text_valid_o;
  logic [CHAR_W-1:0]       text_char_o;
  logic                    last_char_o;

  logic [8*MAX_BASE-1:0]   alphabet_shadow = '0;
  text_char_t              pending_text_q[$];
  int                      mismatch_count = 0;
  int                      cycle_count = 0;

  directed_row_t directed_rows [24] = '{
    '{ALPHA_RESET, 32'd5,          1'b1, ""},
    '{ALPHA_RESET, 32'h8000_0000,  1'b1, ""},
    '{ALPHA_DEC,   32'd0,          1'b1, "0"},
    '{ALPHA_DEC,   32'd7,          1'b1, "7"},
    '{ALPHA_DEC,   32'h7fff_ffff,  1'b1, "2147483647"},
    '{ALPHA_DEC,   32'h8000_0000,  1'b1, "-2147483648"},
    '{ALPHA_DEC,   32'hffff_ffff,  1'b1, "-1"},
    '{ALPHA_DEC,   32'd1234567,    1'b0, ""},
    '{ALPHA_DEC,   32'hffff_6000,  1'b0, ""},
    '{ALPHA_BIN,   32'd0,          1'b1, "0"},
    '{ALPHA_BIN,   32'd1,          1'b1, "1"},
    '{ALPHA_BIN,   32'h8000_0000,  1'b1, "-10000000000000000000000000000000"},
    '{ALPHA_BIN,   32'h7fff_ffff,  1'b1, "1111111111111111111111111111111"},
    '{ALPHA_BIN,   32'hffff_fffb,  1'b0, ""},
    '{ALPHA_HEX,   32'h7fff_ffff,  1'b1, "7FFFFFFF"},
    '{ALPHA_HEX,   32'h8000_0000,  1'b1, "-80000000"},
    '{ALPHA_HEX,   32'h1234_abcd,  1'b0, ""},
    '{ALPHA_FULL,  32'd63,         1'b1, "@"},
    '{ALPHA_FULL,  32'd64,         1'b1, "10"},
    '{ALPHA_FULL,  32'h8000_0000,  1'b0, ""},
    '{ALPHA_SHORT, 32'd9,          1'b1, ""},
    '{ALPHA_DUP,   32'd9,          1'b1, ""},
    '{ALPHA_PLUS,  32'd9,          1'b1, ""},
    '{ALPHA_MINUS, 32'd9,          1'b1, ""}
  };

  signed_integer_to_custom_radix_text #(
    .MAX_BASE(MAX_BASE)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .number_value_i(number_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .text_valid_o  (text_valid_o),
    .text_char_o   (text_char_o),
    .last_char_o   (last_char_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic string alphabet_text(input alphabet_e sel);
    case (sel)
      ALPHA_DEC:   return "0123456789";
      ALPHA_BIN:   return "01";
      ALPHA_HEX:   return "0123456789ABCDEF";
      ALPHA_FULL:  return "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!@";
      ALPHA_SHORT: return "X";
      ALPHA_DUP:   return "0123456789A5";
      ALPHA_PLUS:  return "01+23";
      ALPHA_MINUS: return "-0123";
      default:     return "";
    endcase
  endfunction

  function automatic logic [8*MAX_BASE-1:0] alpha_from_text(input string s);
    logic [8*MAX_BASE-1:0] bits;
    bits = '0;
    for (int k = 0; k < s.len() && k < MAX_BASE; k++) begin
      bits[8*k +: 8] = s[k];
    end
    return bits;
  endfunction

  // Random alphabet, garbage past the terminator; a few kinds are made invalid.
  function automatic logic [8*MAX_BASE-1:0] random_alphabet();
    logic [8*MAX_BASE-1:0] bits;
    bit                    used [256];
    logic [CHAR_W-1:0]     c;
    int                    len;
    int                    kind;
    int                    i;
    int                    j;
    used = '{default: 1'b0};
    for (i = 0; i < NUM_REGS; i++) begin
      bits[REG_W*i +: REG_W] = {$urandom, $urandom};
    end
    kind = $urandom_range(0, 10);
    case (kind)
      0: len = 2;
      1: len = MAX_BASE;
      7: len = $urandom_range(17, MAX_BASE - 1);
      default: len = $urandom_range(2, 16);
    endcase
    used[0] = 1'b1;
    used[CH_PLUS] = 1'b1;
    used[CH_MINUS] = 1'b1;
    for (i = 0; i < len; i++) begin
      do c = CHAR_W'($urandom_range(1, 255)); while (used[c]);
      used[c] = 1'b1;
      bits[8*i +: 8] = c;
    end
    if (len < MAX_BASE) bits[8*len +: 8] = 8'h00;
    i = $urandom_range(0, len - 1);
    case (kind)
      8: begin
        j = (i + 1 + $urandom_range(0, len - 2)) % len;
        bits[8*i +: 8] = bits[8*j +: 8];
      end
      9: bits[8*i +: 8] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      10: bits[8*$urandom_range(0, 1) +: 8] = 8'h00;
      default: ;
    endcase
    return bits;
  endfunction

  function automatic logic [NUM_W-1:0] random_number();
    logic [NUM_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 99);
      1: v = -NUM_W'($urandom_range(1, 99));
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = '1;
          default: v = '0;
        endcase
      end
      3: begin
        v = $urandom >> $urandom_range(0, NUM_W - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Radix of the current alphabet, 0 when it is unusable.
  function automatic int alphabet_radix();
    bit                used [256];
    logic [CHAR_W-1:0] c;
    int                len;
    bit                stop;
    bit                bad;
    used = '{default: 1'b0};
    len = 0;
    stop = 1'b0;
    bad = 1'b0;
    for (int k = 0; k < MAX_BASE && !stop; k++) begin
      c = alphabet_shadow[8*k +: 8];
      if (c == 8'h00) begin
        stop = 1'b1;
      end else begin
        if (used[c] || c == CH_PLUS || c == CH_MINUS) bad = 1'b1;
        used[c] = 1'b1;
        len++;
      end
    end
    return (bad || len < 2) ? 0 : len;
  endfunction

  function automatic void push_text_char(input logic [CHAR_W-1:0] ch, input logic last);
    text_char_t t;
    t.ch = ch;
    t.last = last;
    pending_text_q.push_back(t);
  endfunction

  function automatic void render_number_text(input logic [NUM_W-1:0] value);
    logic [NUM_W-1:0] mag;
    logic [NUM_W-1:0] radix;
    int               digit [MAX_DIGITS];
    int               nd;
    radix = NUM_W'(alphabet_radix());
    if (radix == 0) return;
    if (value[NUM_W-1]) begin
      mag = -value;
      push_text_char(CH_MINUS, 1'b0);
    end else begin
      mag = value;
    end
    nd = 0;
    do begin
      digit[nd] = int'(mag % radix);
      mag = mag / radix;
      nd++;
    end while (mag != 0 && nd < MAX_DIGITS);
    for (int i = nd - 1; i >= 0; i--) begin
      push_text_char(alphabet_shadow[8*digit[i] +: 8], i == 0);
    end
  endfunction

  task automatic send_number(input logic [NUM_W-1:0] value);
    start <= 1'b1;
    number_value_i <= value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      start <= 1'b0;
      number_value_i <= $urandom;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_text();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_text_q.size() != 0) @(posedge clk_i);
  endtask

  // Block idle: no text pending, invalid-alphabet items finished, check done.
  task automatic settle_block();
    drain_text();
    repeat (LATENCY_CYC) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic program_alphabet(input logic [8*MAX_BASE-1:0] bits);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      cfg_wdata_i <= bits[REG_W*i +: REG_W];
      @(posedge clk_i);
      alphabet_shadow[REG_W*i +: REG_W] = bits[REG_W*i +: REG_W];
    end
    // out-of-range index must be dropped
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1));
    cfg_wdata_i <= {$urandom, $urandom};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && text_valid_o) begin
      if (pending_text_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual char %h last %b",
                 $time, text_char_o, last_char_o);
        mismatch_count++;
      end else begin
        want = pending_text_q.pop_front();
        if (text_char_o !== want.ch) begin
          $display("%0t: text_char mismatch: expected %h, actual %h",
                   $time, want.ch, text_char_o);
          mismatch_count++;
        end
        if (last_char_o !== want.last) begin
          $display("%0t: last_char mismatch: expected %b, actual %b",
                   $time, want.last, last_char_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < TIMEOUT_CYC) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    alphabet_e        cur_alpha;
    logic [NUM_W-1:0] num;
    string            txt;
    int               rand_sent;
    int               phase_len;
    int               burst_left;
    bit               steady;
    bit               valid_phase;

    rst_ni = 1'b0;
    start = 1'b0;
    number_value_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_alpha = ALPHA_RESET;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].alpha != cur_alpha) begin
        settle_block();
        program_alphabet(alpha_from_text(alphabet_text(directed_rows[r].alpha)));
        cur_alpha = directed_rows[r].alpha;
      end
      send_number(directed_rows[r].number);
      if (directed_rows[r].typed) begin
        txt = directed_rows[r].text;
        for (int k = 0; k < txt.len(); k++) begin
          push_text_char(txt[k], k == txt.len() - 1);
        end
      end else begin
        render_number_text(directed_rows[r].number);
      end
      idle_for($urandom_range(0, 3));
    end

    rand_sent = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      settle_block();
      program_alphabet(random_alphabet());
      valid_phase = (alphabet_radix() != 0);
      phase_len = valid_phase ? $urandom_range(16, 32) : $urandom_range(3, 6);
      steady = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < phase_len && rand_sent < RANDOM_ITEMS; n++) begin
        num = random_number();
        send_number(num);
        render_number_text(num);
        if (valid_phase) rand_sent++;
        if ($urandom_range(0, 24) == 0) begin
          drain_text();
        end else if (!steady) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_for($urandom_range(1, 12));
            burst_left = $urandom_range(1, 8);
          end
        end
      end
    end

    drain_text();
    repeat (LATENCY_CYC) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ signed_integer_to_custom_radix_text.f @@
+incdir+rtl
rtl/sicrt_pkg.sv
rtl/sicrt_ctrl.sv
rtl/sicrt_dp.sv
rtl/signed_integer_to_custom_radix_text.sv
verif/tb_top.sv
